/* hw/rtl/wsfd_pkg.sv */
// Shared types and constants of the WebSocket frame deframer.
package wsfd_pkg;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_EMPTY   = 3'd1,
        KIND_PROTO   = 3'd2,
        KIND_BIG     = 3'd3,
        KIND_BADCONT = 3'd4
    } t_kind;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_RSV_LO = 4'h3;
    localparam logic [3:0] OP_RSV_HI = 4'h7;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_CTRL_RSV = 4'hb;

    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;

    localparam int unsigned APB_AW = 3;
    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic [30:0] MAX_PAYLOAD_RST = 31'd1048576;

    // One entry of the queue between the parser and the result stage.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [3:0] frame_op;
        logic [3:0] msg_op;
        logic       fin;
        logic       last;
        logic       bad_cont;
    } t_cmd;

    // One result as it leaves the block.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [3:0] frame_op;
        logic [3:0] msg_op;
        logic       fin;
        logic       last;
    } t_res;

endpackage

/* hw/rtl/wsfd_front.sv */
// Frame parser: walks the header, length, key and payload of each frame.
module wsfd_front import wsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic [30:0] i_max_payload,
    output logic        o_wr,
    output t_cmd        o_cmd
);

    typedef enum logic [5:0] {
        PH_HEAD1   = 6'b000001,
        PH_HEAD2   = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_STOPPED = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_head, n_head;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_midx, n_midx;
    logic [3:0]  r_pend, n_pend;

    logic [3:0]  op;
    logic        fin;
    logic [63:0] ext;
    logic        frame_done;

    function automatic logic header_bad(input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [3:0] pend);
        logic [3:0] hop;
        logic       ctrl;
        begin
            hop  = b1[3:0];
            ctrl = hop[3];
            header_bad = !b2[7] || (b1[6:4] != 3'b000)
                || (hop >= OP_RSV_LO && hop <= OP_RSV_HI) || (hop >= OP_CTRL_RSV)
                || (ctrl && (b2[6:0] > CTRL_MAX_LEN)) || (ctrl && !b1[7])
                || ((pend != OP_CONT) && (hop == OP_TEXT || hop == OP_BINARY));
        end
    endfunction

    assign op  = r_head[3:0];
    assign fin = r_head[7];
    assign ext = {r_rem[55:0], i_byte};

    always_comb begin
        n_phase    = r_phase;
        n_head     = r_head;
        n_left     = r_left;
        n_rem      = r_rem;
        n_key      = r_key;
        n_midx     = r_midx;
        n_pend     = r_pend;
        frame_done = 1'b0;
        o_wr       = 1'b0;
        o_cmd.kind     = KIND_PAYLOAD;
        o_cmd.data     = 8'h00;
        o_cmd.frame_op = op;
        o_cmd.msg_op   = (op == OP_CONT) ? r_pend : op;
        o_cmd.fin      = fin;
        o_cmd.last     = 1'b0;
        o_cmd.bad_cont = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                PH_HEAD1: begin
                    n_head  = i_byte;
                    n_phase = PH_HEAD2;
                end
                PH_HEAD2: begin
                    if (header_bad(r_head, i_byte, r_pend)) begin
                        o_wr       = 1'b1;
                        o_cmd.kind = KIND_PROTO;
                        o_cmd.last = 1'b1;
                        n_phase    = PH_STOPPED;
                    end else begin
                        if ((op == OP_TEXT || op == OP_BINARY) && !fin) begin
                            n_pend = op;
                        end
                        n_key  = 32'h0;
                        n_midx = 2'd0;
                        if (i_byte[6:0] == LEN_EXT16) begin
                            n_rem   = 64'h0;
                            n_left  = 4'd2;
                            n_phase = PH_EXTLEN;
                        end else if (i_byte[6:0] == LEN_EXT64) begin
                            n_rem   = 64'h0;
                            n_left  = 4'd8;
                            n_phase = PH_EXTLEN;
                        end else begin
                            n_rem   = {57'h0, i_byte[6:0]};
                            n_left  = 4'd4;
                            n_phase = PH_MASK;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_rem  = ext;
                    n_left = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        if ((ext[63:31] != 33'h0) || (ext[30:0] > i_max_payload)) begin
                            o_wr       = 1'b1;
                            o_cmd.kind = KIND_BIG;
                            o_cmd.last = 1'b1;
                            n_phase    = PH_STOPPED;
                        end else begin
                            n_left  = 4'd4;
                            n_midx  = 2'd0;
                            n_phase = PH_MASK;
                        end
                    end
                end
                PH_MASK: begin
                    n_key[8*r_midx +: 8] = i_byte;
                    n_midx = r_midx + 2'd1;
                    n_left = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        n_midx = 2'd0;
                        if (r_rem == 64'h0) begin
                            o_wr       = 1'b1;
                            o_cmd.kind = KIND_EMPTY;
                            frame_done = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_wr       = 1'b1;
                    o_cmd.data = i_byte ^ r_key[8*r_midx +: 8];
                    n_midx     = r_midx + 2'd1;
                    n_rem      = r_rem - 64'd1;
                    frame_done = (r_rem == 64'd1);
                end
                PH_STOPPED: begin
                end
                default: begin
                end
            endcase
        end
        // End of frame: mark the last result or flag a bad continuation, and settle the message state.
        if (frame_done) begin
            if (op == OP_CONT && r_pend == OP_CONT) begin
                o_cmd.bad_cont = 1'b1;
                n_phase        = PH_STOPPED;
            end else begin
                o_cmd.last = 1'b1;
                if (op == OP_CLOSE) begin
                    n_phase = PH_STOPPED;
                end else begin
                    if (op <= OP_BINARY && fin) begin
                        n_pend = OP_CONT;
                    end
                    n_phase = PH_HEAD1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
            r_head  <= 8'h00;
            r_left  <= 4'd0;
            r_rem   <= 64'h0;
            r_key   <= 32'h0;
            r_midx  <= 2'd0;
            r_pend  <= OP_CONT;
        end else begin
            r_phase <= n_phase;
            r_head  <= n_head;
            r_left  <= n_left;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_midx  <= n_midx;
            r_pend  <= n_pend;
        end
    end

`ifndef SYNTHESIS
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOPPED |=> r_phase == PH_STOPPED)
        else $error("parser left the stopped phase");
    a_badcont_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr && o_cmd.bad_cont) |=> r_phase == PH_STOPPED)
        else $error("bad continuation did not stop the parser");
`endif

endmodule

/* hw/rtl/wsfd_fifo.sv */
// Short register queue between the parser and the result stage.
module wsfd_fifo import wsfd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    input  logic i_rd,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CW'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && !i_rd && o_full))
        else $error("write into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("read from an empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count did not follow a write");
`endif

endmodule

/* hw/rtl/wsfd_back.sv */
// Result stage: turns queue entries into one or two results.
module wsfd_back import wsfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_head,
    input  logic i_empty,
    input  logic i_pop,
    output logic o_rd,
    output t_res o_res
);

    logic r_sub, n_sub;
    logic taken;

    assign taken = i_pop && !i_empty;
    assign o_rd  = taken && (!i_head.bad_cont || r_sub);

    always_comb begin
        o_res.kind     = i_head.kind;
        o_res.data     = i_head.data;
        o_res.frame_op = i_head.frame_op;
        o_res.msg_op   = i_head.msg_op;
        o_res.fin      = i_head.fin;
        o_res.last     = i_head.last;
        if (r_sub) begin
            // Second result of an entry: the bad continuation report.
            o_res.kind = KIND_BADCONT;
            o_res.data = 8'h00;
            o_res.last = 1'b1;
        end
        n_sub = r_sub;
        if (taken) begin
            n_sub = i_head.bad_cont && !r_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else begin
            r_sub <= n_sub;
        end
    end

`ifndef SYNTHESIS
    a_sub_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_empty && i_head.bad_cont))
        else $error("second result without a bad continuation entry");
`endif

endmodule

/* hw/rtl/websocket_frame_deframer.sv */
// Top level of the WebSocket client frame deframer.
//
//   Channel   Direction  Handshake             Carries
//   input     in         push / full           i_data_byte
//   result    out        empty / pop           o_result_kind .. o_last_of_frame
//   config    in         APB psel/penable      max_payload at byte address 0
//
// One byte is accepted per clock cycle while the result queue has room; the
// parser handles each byte in the cycle it is taken, and its result enters
// the queue at that same edge, so a result can be popped in the next cycle.
// A bad continuation frame yields two results from one queue entry, popped one
// after the other; QUEUE_DEPTH entries of slack absorb pop stalls.
// Reset is synchronous and active low; it returns the parser to the first
// header byte, empties the queue and sets max_payload to 1048576.
// After a protocol error, an oversized length, a bad continuation or a
// complete close frame, bytes are still taken but yield no results.
module websocket_frame_deframer import wsfd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Byte input, seen as the write side of a queue.
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_data_byte,
    // Results, seen as the read side of a queue.
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        o_result_kind,
    output logic [7:0]        o_payload_byte,
    output logic [3:0]        o_frame_opcode,
    output logic [3:0]        o_message_opcode,
    output logic              o_frame_final,
    output logic              o_last_of_frame,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [30:0] r_max_payload;
    logic        take;
    logic        fifo_wr;
    logic        fifo_rd;
    t_cmd        front_cmd;
    t_cmd        head;
    t_res        res;

    // The single register sits at index 0; the low address bits select a byte
    // within the word and are not decoded.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {1'b0, r_max_payload} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD)) begin
            r_max_payload <= pwdata[30:0];
        end
    end

    // A byte transaction completes whenever the queue can take its result.
    assign take = push && !full;

    wsfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_byte        (i_data_byte),
        .i_max_payload (r_max_payload),
        .o_wr          (fifo_wr),
        .o_cmd         (front_cmd)
    );

    wsfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_cmd   (front_cmd),
        .i_rd    (fifo_rd),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    wsfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .i_pop   (pop),
        .o_rd    (fifo_rd),
        .o_res   (res)
    );

    assign o_result_kind    = res.kind;
    assign o_payload_byte   = res.data;
    assign o_frame_opcode   = res.frame_op;
    assign o_message_opcode = res.msg_op;
    assign o_frame_final    = res.fin;
    assign o_last_of_frame  = res.last;

endmodule

/* verif/wsfd_stream_checker.sv */
// Checker for the frame deframer: mirrors its parser and compares every result transaction.
module wsfd_stream_checker import wsfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [7:0]        i_data_byte,
    input  logic              i_pop,
    input  logic              i_empty,
    input  logic [2:0]        i_result_kind,
    input  logic [7:0]        i_payload_byte,
    input  logic [3:0]        i_frame_opcode,
    input  logic [3:0]        i_message_opcode,
    input  logic              i_frame_final,
    input  logic              i_last_of_frame,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int unsigned       o_deframed_due,
    output int unsigned       o_mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_REPORTS = 40;
    // An open-message opcode of zero means that no fragmented message is open.
    localparam logic [3:0] NO_MESSAGE = OP_CONT;

    typedef enum logic [2:0] {
        PARSE_HEAD1,
        PARSE_HEAD2,
        PARSE_EXT_LEN,
        PARSE_MASK,
        PARSE_PAYLOAD,
        PARSE_STOPPED
    } t_parse_phase;

    t_parse_phase parse_phase;
    logic [7:0]   frame_head;
    logic [3:0]   field_left;
    logic [63:0]  payload_left;
    logic [31:0]  mask_key;
    logic [1:0]   key_index;
    logic [3:0]   open_opcode;
    logic [30:0]  max_payload;
    t_res         deframed_q[$];
    int unsigned  mismatch_count = 0;

    function automatic t_res make_result(input t_kind kind, input logic [7:0] data,
                                         input logic last);
        t_res r;
        r.kind     = kind;
        r.data     = data;
        r.frame_op = frame_head[3:0];
        r.msg_op   = (frame_head[3:0] == OP_CONT) ? open_opcode : frame_head[3:0];
        r.fin      = frame_head[7];
        r.last     = last;
        return r;
    endfunction

    function automatic logic header_bad(input logic [7:0] len_byte);
        logic [3:0] op;
        logic       control;
        op      = frame_head[3:0];
        control = (op >= OP_CLOSE);
        return !len_byte[7] || (frame_head[6:4] != 3'b000)
            || (op >= OP_RSV_LO && op <= OP_RSV_HI) || (op >= OP_CTRL_RSV)
            || (control && (len_byte[6:0] > CTRL_MAX_LEN || !frame_head[7]))
            || (open_opcode != NO_MESSAGE && (op == OP_TEXT || op == OP_BINARY));
    endfunction

    // The frame is complete; r is its final result, not yet marked as last.
    task automatic close_frame(input t_res r);
        if (frame_head[3:0] == OP_CONT && open_opcode == NO_MESSAGE) begin
            deframed_q.push_back(r);
            deframed_q.push_back(make_result(KIND_BADCONT, 8'h00, 1'b1));
            parse_phase = PARSE_STOPPED;
        end else begin
            r.last = 1'b1;
            deframed_q.push_back(r);
            if (frame_head[3:0] == OP_CLOSE) begin
                parse_phase = PARSE_STOPPED;
            end else begin
                if (frame_head[3:0] <= OP_BINARY && frame_head[7])
                    open_opcode = NO_MESSAGE;
                parse_phase = PARSE_HEAD1;
            end
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] key_byte;
        case (parse_phase)
            PARSE_HEAD1: begin
                frame_head  = b;
                parse_phase = PARSE_HEAD2;
            end
            PARSE_HEAD2: begin
                if (header_bad(b)) begin
                    deframed_q.push_back(make_result(KIND_PROTO, 8'h00, 1'b1));
                    parse_phase = PARSE_STOPPED;
                end else begin
                    if ((frame_head[3:0] == OP_TEXT || frame_head[3:0] == OP_BINARY)
                            && !frame_head[7])
                        open_opcode = frame_head[3:0];
                    payload_left = '0;
                    mask_key     = '0;
                    key_index    = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        field_left  = 4'd2;
                        parse_phase = PARSE_EXT_LEN;
                    end else if (b[6:0] == LEN_EXT64) begin
                        field_left  = 4'd8;
                        parse_phase = PARSE_EXT_LEN;
                    end else begin
                        payload_left = {57'b0, b[6:0]};
                        field_left   = 4'd4;
                        parse_phase  = PARSE_MASK;
                    end
                end
            end
            PARSE_EXT_LEN: begin
                payload_left = {payload_left[55:0], b};
                field_left   = field_left - 4'd1;
                if (field_left == 4'd0) begin
                    if (payload_left > {33'b0, max_payload}) begin
                        deframed_q.push_back(make_result(KIND_BIG, 8'h00, 1'b1));
                        parse_phase = PARSE_STOPPED;
                    end else begin
                        field_left  = 4'd4;
                        key_index   = '0;
                        parse_phase = PARSE_MASK;
                    end
                end
            end
            PARSE_MASK: begin
                mask_key[{key_index, 3'b000} +: 8] = b;
                key_index  = key_index + 2'd1;
                field_left = field_left - 4'd1;
                if (field_left == 4'd0) begin
                    key_index = '0;
                    if (payload_left == '0)
                        close_frame(make_result(KIND_EMPTY, 8'h00, 1'b0));
                    else
                        parse_phase = PARSE_PAYLOAD;
                end
            end
            PARSE_PAYLOAD: begin
                key_byte     = mask_key[{key_index, 3'b000} +: 8];
                key_index    = key_index + 2'd1;
                payload_left = payload_left - 64'd1;
                if (payload_left != '0)
                    deframed_q.push_back(make_result(KIND_PAYLOAD, b ^ key_byte, 1'b0));
                else
                    close_frame(make_result(KIND_PAYLOAD, b ^ key_byte, 1'b0));
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            parse_phase  = PARSE_HEAD1;
            frame_head   = '0;
            field_left   = '0;
            payload_left = '0;
            mask_key     = '0;
            key_index    = '0;
            open_opcode  = NO_MESSAGE;
            max_payload  = MAX_PAYLOAD_RST;
            deframed_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_AW-1:2] == REG_MAX_PAYLOAD)
                max_payload = i_pwdata[30:0];
            if (i_push && !i_full)
                deframe_byte(i_data_byte);
            if (i_pop && !i_empty) begin
                got.kind     = t_kind'(i_result_kind);
                got.data     = i_payload_byte;
                got.frame_op = i_frame_opcode;
                got.msg_op   = i_message_opcode;
                got.fin      = i_frame_final;
                got.last     = i_last_of_frame;
                if (deframed_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with none due: exp none got kind %0d byte %02h",
                                 $time, i_result_kind, i_payload_byte);
                end else begin
                    want = deframed_q.pop_front();
                    // Fields in order: kind/byte/frame op/message op/fin/last.
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch exp %0d/%02h/%h/%h/%b/%b got %0d/%02h/%h/%h/%b/%b",
                                     $time, want.kind, want.data, want.frame_op, want.msg_op,
                                     want.fin, want.last, got.kind, got.data, got.frame_op,
                                     got.msg_op, got.fin, got.last);
                    end
                end
            end
        end
        o_deframed_due   = deframed_q.size();
        o_mismatch_count = mismatch_count;
    end

endmodule

/* verif/tb_websocket_frame_deframer.sv */
// Testbench top: feeds frame streams to the deframer, sets its limit register and gives the verdict.
module tb_websocket_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;
    import wsfd_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 6;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int unsigned SEGMENT_BYTES = 36;
    localparam int unsigned NOISE_BYTES   = 16;

    // Control opcodes that the package leaves unnamed.
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'ha;

    localparam logic [APB_AW-1:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
    // The next word up holds no register; writes there must change nothing.
    localparam logic [APB_AW-1:0] ADDR_SPARE       = {~REG_MAX_PAYLOAD, 2'b00};

    // How the payload length of a frame header is encoded.
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    // The stream ends in one of these; each of them halts the deframer for good.
    typedef enum logic [3:0] {
        END_NO_MASK,
        END_RSV_BITS,
        END_RSV_OPCODE,
        END_CTRL_LONG,
        END_CTRL_FRAG,
        END_NEW_MESSAGE,
        END_TOO_BIG,
        END_BAD_CONT,
        END_CLOSE
    } t_ending;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [7:0]        i_data_byte;
    logic              empty;
    logic              pop = 1'b0;
    logic [2:0]        o_result_kind;
    logic [7:0]        o_payload_byte;
    logic [3:0]        o_frame_opcode;
    logic [3:0]        o_message_opcode;
    logic              o_frame_final;
    logic              o_last_of_frame;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned deframed_due;
    int unsigned mismatch_count;
    int          cycle_count = 0;
    int unsigned bytes_sent = 0;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int unsigned send_gap_pct = 0;
    int unsigned pop_stall_pct = 0;

    // Stimulus-side view of the stream, used only to keep the random frames legal:
    // whether a fragmented message is open, and the limit last written.
    logic        message_open = 1'b0;
    logic [30:0] max_payload_now = MAX_PAYLOAD_RST;

    always #(CLK_HALF) i_clk = ~i_clk;

    websocket_frame_deframer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_frame_opcode   (o_frame_opcode),
        .o_message_opcode (o_message_opcode),
        .o_frame_final    (o_frame_final),
        .o_last_of_frame  (o_last_of_frame),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    wsfd_stream_checker stream_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (i_data_byte),
        .i_pop            (pop),
        .i_empty          (empty),
        .i_result_kind    (o_result_kind),
        .i_payload_byte   (o_payload_byte),
        .i_frame_opcode   (o_frame_opcode),
        .i_message_opcode (o_message_opcode),
        .i_frame_final    (o_frame_final),
        .i_last_of_frame  (o_last_of_frame),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_deframed_due   (deframed_due),
        .o_mismatch_count (mismatch_count)
    );

    // The receiver decides afresh at every edge whether it takes a result transaction.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Watchdog: a hung handshake or a result that never turns up ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offers one byte and returns in the time step of the edge that accepted it.
    // push is left high, so that back-to-back bytes need no second assignment to it
    // within the same step; the next call either keeps it high or drops it for a gap.
    // full is looked at on the falling edge, where it is settled for the coming edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
        bytes_sent++;
    endtask

    // The two header bytes and any extended length, with the mask bit set.
    task automatic send_header(input logic [7:0] head, input logic [63:0] len,
                               input t_len_form form);
        send_byte(head);
        case (form)
            FORM_EXT16: begin
                send_byte({1'b1, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FORM_EXT64: begin
                send_byte({1'b1, LEN_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
            default: send_byte({1'b1, len[6:0]});
        endcase
    endtask

    // A whole frame with a random masking key and random payload bytes.
    task automatic send_frame(input logic [7:0] head, input int unsigned len,
                              input t_len_form form);
        send_header(head, 64'(len), form);
        repeat (4) send_byte(8'($urandom_range(255)));
        repeat (len) send_byte(8'($urandom_range(255)));
    endtask

    // A legal frame: pings and pongs between data frames, and text or binary
    // messages that are sometimes split into continuation fragments. Extended
    // lengths are kept within the current limit so that the stream never halts.
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned ext_cap;
        logic [3:0]  op;
        logic        fin;
        t_len_form   form;
        pick = $urandom_range(99);
        fin  = 1'($urandom_range(1));
        form = FORM_SHORT;
        if (pick < 20) begin
            op  = (pick < 10) ? OP_PING : OP_PONG;
            fin = 1'b1;
            len = ($urandom_range(15) == 0) ? int'(CTRL_MAX_LEN) : $urandom_range(8);
        end else begin
            op      = message_open ? OP_CONT : ($urandom_range(1) ? OP_TEXT : OP_BINARY);
            ext_cap = (max_payload_now < 31'd80) ? int'(max_payload_now) : 80;
            pick    = $urandom_range(19);
            if (pick < 2) begin
                form = FORM_EXT16;
                len  = $urandom_range(ext_cap);
            end else if (pick == 2) begin
                form = FORM_EXT64;
                len  = $urandom_range(ext_cap);
            end else begin
                len  = $urandom_range(12);
            end
            message_open = !fin;
        end
        send_frame({fin, 3'b000, op}, len, form);
    endtask

    // Drops push, waits for every predicted result to be taken and lets the
    // pipeline drain. A header or key byte leaves nothing behind, so the
    // settling wait only has to cover the registered result path.
    task automatic wait_idle();
        push <= 1'b0;
        @(negedge i_clk);
        while (deframed_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge with pready high.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_MAX_PAYLOAD)
            max_payload_now = value[30:0];
    endtask

    initial begin
        int unsigned target;
        int unsigned pick;
        t_ending     ending;
        logic [3:0]  data_op;
        logic [63:0] big_len;
        t_len_form   big_form;

        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_data_byte <= 8'h00;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= 32'h0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset limit, with no idling on either side.
        // A two-byte text frame whose key and payload bytes sit at both extremes.
        send_header({1'b1, 3'b000, OP_TEXT}, 64'd2, FORM_SHORT);
        repeat (4) send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'hff);
        // An empty binary frame gives only the empty-frame transaction.
        send_frame({1'b1, 3'b000, OP_BINARY}, 0, FORM_SHORT);
        // A fragmented text message with a ping in the middle, closed by an empty
        // continuation whose zero length comes in the 16-bit form.
        send_frame({1'b0, 3'b000, OP_TEXT}, 1, FORM_SHORT);
        send_frame({1'b1, 3'b000, OP_PING}, 0, FORM_SHORT);
        send_frame({1'b1, 3'b000, OP_CONT}, 0, FORM_EXT16);
        wait_idle();

        // Limit at zero: only zero-length extended frames pass. The sender idles.
        write_reg(ADDR_MAX_PAYLOAD, 32'h0000_0000);
        send_gap_pct = 84;
        target = bytes_sent + SEGMENT_BYTES;
        while (bytes_sent < target) send_random_frame();
        wait_idle();

        // Limit at its top (bit 31 of the write data is not part of the register).
        // The receiver stalls.
        write_reg(ADDR_MAX_PAYLOAD, 32'hffff_ffff);
        send_gap_pct = 0;
        pop_stall_pct <= 84;
        target = bytes_sent + SEGMENT_BYTES;
        while (bytes_sent < target) send_random_frame();
        wait_idle();

        // A middling limit and a frame exactly at it; both sides idle now and then.
        write_reg(ADDR_MAX_PAYLOAD, 32'($urandom_range(160, 130)));
        send_gap_pct = 19;
        pop_stall_pct <= 19;
        send_frame({1'b1, 3'b000, message_open ? OP_CONT : OP_BINARY},
                   int'(max_payload_now), FORM_EXT16);
        message_open = 1'b0;
        target = bytes_sent + SEGMENT_BYTES;
        while (bytes_sent < target) send_random_frame();
        wait_idle();

        // A write to the empty address must leave the limit alone, then any limit.
        write_reg(ADDR_SPARE, $urandom);
        write_reg(ADDR_MAX_PAYLOAD, $urandom);
        send_gap_pct = 0;
        pop_stall_pct <= 0;
        target = bytes_sent + SEGMENT_BYTES;
        while (bytes_sent < target) send_random_frame();

        // The stream ends in one halting case picked by the seed. After it the
        // deframer must take bytes and give no further transaction.
        ending  = t_ending'($urandom_range(END_CLOSE));
        data_op = message_open ? OP_CONT : OP_BINARY;
        case (ending)
            END_NO_MASK: begin
                send_byte({1'b1, 3'b000, data_op});
                send_byte({1'b0, 7'($urandom_range(127))});
            end
            END_RSV_BITS: begin
                send_byte({1'b1, 3'($urandom_range(7, 1)), data_op});
                send_byte({1'b1, 7'($urandom_range(125))});
            end
            END_RSV_OPCODE: begin
                pick = $urandom_range(9);
                send_byte({1'b1, 3'b000,
                           (pick < 5) ? 4'(OP_RSV_LO + pick) : 4'(OP_CTRL_RSV + pick - 5)});
                send_byte({1'b1, 7'($urandom_range(127))});
            end
            END_CTRL_LONG: begin
                // A control frame may carry at most 125 bytes.
                send_byte({1'b1, 3'b000, 4'(OP_CLOSE + $urandom_range(2))});
                send_byte({1'b1, 7'(LEN_EXT16 + $urandom_range(1))});
            end
            END_CTRL_FRAG: begin
                // A control frame must not be fragmented.
                send_byte({1'b0, 3'b000, 4'(OP_CLOSE + $urandom_range(2))});
                send_byte({1'b1, 7'($urandom_range(125))});
            end
            END_NEW_MESSAGE: begin
                if (!message_open)
                    send_frame({1'b0, 3'b000, OP_TEXT}, $urandom_range(4), FORM_SHORT);
                send_byte({1'($urandom_range(1)), 3'b000,
                           $urandom_range(1) ? OP_TEXT : OP_BINARY});
                send_byte({1'b1, 7'($urandom_range(125))});
            end
            END_TOO_BIG: begin
                if (max_payload_now != 31'h7fff_ffff && $urandom_range(1)) begin
                    big_len  = 64'(max_payload_now) + 64'd1;
                    big_form = (big_len <= 64'hffff) ? FORM_EXT16 : FORM_EXT64;
                end else begin
                    big_len  = {$urandom, $urandom} | 64'h8000_0000;
                    big_form = FORM_EXT64;
                end
                send_header({1'b1, 3'b000, data_op}, big_len, big_form);
            end
            END_BAD_CONT: begin
                // Close any open message first, so that the continuation has nothing
                // to continue; an empty one is flagged after its empty-frame result.
                if (message_open)
                    send_frame({1'b1, 3'b000, OP_CONT}, $urandom_range(4), FORM_SHORT);
                send_frame({1'($urandom_range(1)), 3'b000, OP_CONT},
                           $urandom_range(3), FORM_SHORT);
            end
            default: begin
                send_frame({1'b1, 3'b000, OP_CLOSE}, $urandom_range(5), FORM_SHORT);
            end
        endcase
        repeat (NOISE_BYTES) send_byte(8'($urandom_range(255)));
        wait_idle();

        if (mismatch_count == 0 && deframed_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* websocket_frame_deframer.f */
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_front.sv
hw/rtl/wsfd_fifo.sv
hw/rtl/wsfd_back.sv
hw/rtl/websocket_frame_deframer.sv
verif/wsfd_stream_checker.sv
verif/tb_websocket_frame_deframer.sv
